/* design/dmpt_pkg.sv */
// shared types, operation codes and a digit helper for the digit matrix core
`timescale 1ns / 1ps
`default_nettype none
package dmpt_pkg;

    localparam int MAX_SIZE_DEF = 16;
    localparam int DIGIT_BASE   = 10;

    typedef logic [2:0] t_op;
    typedef logic [3:0] t_idx;
    typedef logic [3:0] t_digit;
    typedef logic [4:0] t_size;

    localparam t_op OP_WRITE     = 3'd0;
    localparam t_op OP_SWAP_ROW  = 3'd1;
    localparam t_op OP_SWAP_COL  = 3'd2;
    localparam t_op OP_INC       = 3'd3;
    localparam t_op OP_DEC       = 3'd4;
    localparam t_op OP_TRANSPOSE = 3'd5;
    localparam t_op OP_READ      = 3'd6;

    localparam t_size  SIZE_RST  = 5'd16;
    localparam t_digit DIGIT_MAX = 4'd9;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic offset_inc;
        logic offset_dec;
        logic flip;
        logic swap_first;
        logic swap_second;
        logic store_wr;
        logic store_rd;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  in_op;
        logic in_ok;
        t_op  cur_op;
        logic out_busy;
    } t_dp_status;

    // mod 10 of a value below twenty
    function automatic t_digit fold10(input logic [4:0] v);
        logic [4:0] r;
        r = (v >= 5'(DIGIT_BASE)) ? v - 5'(DIGIT_BASE) : v;
        return r[3:0];
    endfunction

endpackage
`default_nettype wire

/* design/dmpt_cmd_if.sv */
// command channel: operation, two indices and a digit
`timescale 1ns / 1ps
`default_nettype none
interface dmpt_cmd_if;
    logic            valid;
    logic            ready;
    dmpt_pkg::t_op   operation;
    dmpt_pkg::t_idx  first_index;
    dmpt_pkg::t_idx  second_index;
    dmpt_pkg::t_digit digit_in;

    modport source (output valid, operation, first_index, second_index, digit_in,
                    input ready);
    modport sink (input valid, operation, first_index, second_index, digit_in,
                  output ready);
endinterface
`default_nettype wire

/* design/dmpt_res_if.sv */
// result channel: one digit per read
`timescale 1ns / 1ps
`default_nettype none
interface dmpt_res_if;
    logic             valid;
    logic             ready;
    dmpt_pkg::t_digit digit_out;

    modport source (output valid, digit_out, input ready);
    modport sink (input valid, digit_out, output ready);
endinterface
`default_nettype wire

/* design/dmpt_cfg_if.sv */
// configuration write channel for the matrix size register
`timescale 1ns / 1ps
`default_nettype none
interface dmpt_cfg_if;
    logic            valid;
    logic            ready;
    dmpt_pkg::t_size matrix_size;

    modport source (output valid, matrix_size, input ready);
    modport sink (input valid, matrix_size, output ready);
endinterface
`default_nettype wire

/* design/dmpt_ctrl.sv */
// command sequencer: steps each command through map lookup, store access and result
`timescale 1ns / 1ps
`default_nettype none
module dmpt_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cmd_valid,
    output logic                      o_cmd_ready,
    input  wire dmpt_pkg::t_dp_status i_status,
    output dmpt_pkg::t_dp_cmd         o_cmd
);
    import dmpt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAP   = 2'd1;
    localparam logic [1:0] S_SWAP2 = 2'd2;
    localparam logic [1:0] S_READ  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign accept      = i_cmd_valid && o_cmd_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    case (i_status.in_op)
                        OP_WRITE, OP_SWAP_ROW, OP_SWAP_COL: begin
                            if (i_status.in_ok) begin
                                n_state = S_MAP;
                            end
                        end
                        OP_READ: begin
                            n_state = i_status.in_ok ? S_MAP : S_READ;
                        end
                        OP_INC:       o_cmd.offset_inc = 1'b1;
                        OP_DEC:       o_cmd.offset_dec = 1'b1;
                        OP_TRANSPOSE: o_cmd.flip       = 1'b1;
                        default: begin
                        end
                    endcase
                end
            end
            S_MAP: begin
                if (i_status.cur_op inside {OP_SWAP_ROW, OP_SWAP_COL}) begin
                    o_cmd.swap_first = 1'b1;
                    n_state          = S_SWAP2;
                end else if (i_status.cur_op == OP_READ) begin
                    o_cmd.store_rd = 1'b1;
                    n_state        = S_READ;
                end else begin
                    o_cmd.store_wr = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SWAP2: begin
                o_cmd.swap_second = 1'b1;
                n_state           = S_IDLE;
            end
            S_READ: begin
                // hold until the output register is free
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* design/dmpt_dp.sv */
// datapath: size register, lazy row and column maps, digit store and output register
`timescale 1ns / 1ps
`default_nettype none
module dmpt_dp #(
    parameter int MAX_SIZE = dmpt_pkg::MAX_SIZE_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire dmpt_pkg::t_size       i_cfg_size,
    input  wire dmpt_pkg::t_op         i_operation,
    input  wire dmpt_pkg::t_idx        i_first_index,
    input  wire dmpt_pkg::t_idx        i_second_index,
    input  wire dmpt_pkg::t_digit      i_digit_in,
    input  wire logic                  i_res_ready,
    output logic                       o_res_valid,
    output dmpt_pkg::t_digit           o_digit_out,
    input  wire dmpt_pkg::t_dp_cmd     i_cmd,
    output dmpt_pkg::t_dp_status       o_status
);
    import dmpt_pkg::*;

    localparam int AW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SAW   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1;
    localparam int DEPTH = MAX_SIZE * MAX_SIZE;

    t_size  r_size;
    t_op    r_op;
    logic   r_ok;
    t_idx   r_i;
    t_idx   r_j;
    t_digit r_digit;
    t_digit r_offset;
    logic   r_flip;

    logic [AW-1:0] row_mem [MAX_SIZE];
    logic [AW-1:0] col_mem [MAX_SIZE];
    logic [MAX_SIZE-1:0] r_row_vld;
    logic [MAX_SIZE-1:0] r_col_vld;
    logic [AW-1:0] r_rq0, r_rq1, r_cq0, r_cq1;
    logic          r_rv0, r_rv1, r_cv0, r_cv1;

    t_digit store_mem [DEPTH];
    t_digit r_store_q;

    logic   r_out_vld;
    t_digit r_out_digit;

    logic          in_ok;
    logic [AW-1:0] in_a0, in_a1, cur_a0, cur_a1;
    logic [AW-1:0] row0, row1, col0, col1, phys_r, phys_c;
    logic [SAW-1:0] store_addr;
    logic          use_col;
    logic          map_we;
    logic [AW-1:0] map_waddr, map_wdata;
    t_digit        wr_digit, rd_digit, d_norm;

    assign in_ok = ({1'b0, i_first_index} < r_size) && ({1'b0, i_second_index} < r_size)
                   && (int'(i_first_index) < MAX_SIZE) && (int'(i_second_index) < MAX_SIZE);
    assign in_a0  = AW'(i_first_index);
    assign in_a1  = AW'(i_second_index);
    assign cur_a0 = AW'(r_i);
    assign cur_a1 = AW'(r_j);

    // an entry never swapped still holds its own index
    assign row0 = r_rv0 ? r_rq0 : cur_a0;
    assign row1 = r_rv1 ? r_rq1 : cur_a1;
    assign col0 = r_cv0 ? r_cq0 : cur_a0;
    assign col1 = r_cv1 ? r_cq1 : cur_a1;

    assign phys_r     = r_flip ? row1 : row0;
    assign phys_c     = r_flip ? col0 : col1;
    assign store_addr = SAW'(int'(phys_r) * MAX_SIZE + int'(phys_c));

    // under transpose a row swap lands on the column map and vice versa
    assign use_col   = (r_op == OP_SWAP_COL) ^ r_flip;
    assign map_we    = i_cmd.swap_first || i_cmd.swap_second;
    assign map_waddr = i_cmd.swap_first ? cur_a0 : cur_a1;
    assign map_wdata = use_col ? (i_cmd.swap_first ? col1 : col0)
                               : (i_cmd.swap_first ? row1 : row0);

    assign d_norm   = fold10({1'b0, r_digit});
    assign wr_digit = fold10(5'(d_norm) + 5'(DIGIT_BASE) - 5'(r_offset));
    assign rd_digit = fold10(5'(r_store_q) + 5'(r_offset));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= SIZE_RST;
            r_offset  <= '0;
            r_flip    <= 1'b0;
            r_row_vld <= '0;
            r_col_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_size <= i_cfg_size;
            end
            if (i_cmd.offset_inc) begin
                r_offset <= (r_offset == DIGIT_MAX) ? '0 : r_offset + 4'd1;
            end else if (i_cmd.offset_dec) begin
                r_offset <= (r_offset == '0) ? DIGIT_MAX : r_offset - 4'd1;
            end
            if (i_cmd.flip) begin
                r_flip <= !r_flip;
            end
            if (map_we && use_col) begin
                r_col_vld[map_waddr] <= 1'b1;
            end
            if (map_we && !use_col) begin
                r_row_vld[map_waddr] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // command capture and registered map reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_operation;
            r_ok    <= in_ok;
            r_i     <= i_first_index;
            r_j     <= i_second_index;
            r_digit <= i_digit_in;
            r_rq0   <= row_mem[in_a0];
            r_rq1   <= row_mem[in_a1];
            r_cq0   <= col_mem[in_a0];
            r_cq1   <= col_mem[in_a1];
            r_rv0   <= r_row_vld[in_a0];
            r_rv1   <= r_row_vld[in_a1];
            r_cv0   <= r_col_vld[in_a0];
            r_cv1   <= r_col_vld[in_a1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we && use_col) begin
            col_mem[map_waddr] <= map_wdata;
        end
        if (map_we && !use_col) begin
            row_mem[map_waddr] <= map_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_wr) begin
            store_mem[store_addr] <= wr_digit;
        end
        if (i_cmd.store_rd) begin
            r_store_q <= store_mem[store_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_digit <= r_ok ? rd_digit : '0;
        end
    end

    assign o_res_valid = r_out_vld;
    assign o_digit_out = r_out_digit;

    assign o_status.in_op    = i_operation;
    assign o_status.in_ok    = in_ok;
    assign o_status.cur_op   = r_op;
    assign o_status.out_busy = r_out_vld && !i_res_ready;

endmodule
`default_nettype wire

/* design/digit_matrix_permute_transform_core.sv */
// top level of the digit matrix core: sequencer, datapath and channel hookup
//
//  channel  | dir | payload                                        | transfer when
//  i_cfg    | in  | matrix_size                                    | valid & ready (always ready)
//  i_cmd    | in  | operation, first_index, second_index, digit_in | valid & ready
//  o_res    | out | digit_out (reads only)                         | valid & ready
//
// increment, decrement, transpose, unused codes and out-of-range writes or swaps: done on acceptance
// in-range write: map memory read, then store write
// swap: map read, then two writes through the single map write port
// read: map read, store read, load output register when free; out of range only the load
// reset clears maps to identity through valid bits, offset, transpose flag, size to 16
// a finished result waits in the output register while the next command is taken
`timescale 1ns / 1ps
`default_nettype none
module digit_matrix_permute_transform_core #(
    parameter int MAX_SIZE = dmpt_pkg::MAX_SIZE_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dmpt_cfg_if.sink   i_cfg,
    dmpt_cmd_if.sink   i_cmd,
    dmpt_res_if.source o_res
);
    import dmpt_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       cmd_ready;

    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = cmd_ready;

    dmpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (cmd_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    dmpt_dp #(
        .MAX_SIZE (MAX_SIZE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_size     (i_cfg.matrix_size),
        .i_operation    (i_cmd.operation),
        .i_first_index  (i_cmd.first_index),
        .i_second_index (i_cmd.second_index),
        .i_digit_in     (i_cmd.digit_in),
        .i_res_ready    (o_res.ready),
        .o_res_valid    (o_res.valid),
        .o_digit_out    (o_res.digit_out),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status)
    );

`ifndef ASSERT_OFF
    a_no_store_wr_on_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |-> !dp_cmd.store_wr)
        else $error("store written in the cycle a command is taken");

    a_swap_pairs : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.swap_second |-> $past(dp_cmd.swap_first))
        else $error("second half of swap without first half");

    a_load_only_on_read : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |-> (dp_status.cur_op == OP_READ))
        else $error("result loaded for a command that is not a read");

    a_load_needs_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |-> !(o_res.valid && !o_res.ready))
        else $error("result overwritten before its transfer");
`endif

endmodule
`default_nettype wire

/* test/dmpt_matrix_checker.sv */
// channel monitor with a digit matrix predictor and result comparison
`timescale 1ns / 1ps
module dmpt_matrix_checker #(
    parameter int MAX_SIZE = dmpt_pkg::MAX_SIZE_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dmpt_cfg_if       i_cfg,
    dmpt_cmd_if       i_cmd,
    dmpt_res_if       i_res,
    output int        o_errors,
    output int        o_pending
);
    import dmpt_pkg::*;

    t_digit cell_digits [MAX_SIZE*MAX_SIZE];
    t_idx   row_perm    [MAX_SIZE];
    t_idx   col_perm    [MAX_SIZE];
    logic   flipped;
    t_digit shift;
    t_size  size_reg;
    t_digit read_digits_q [$];
    int     mismatches;

    // physical cell behind logical (r,c), through the maps and the transpose flag
    function automatic int cell_at(t_idx r, t_idx c);
        t_idx a;
        t_idx b;
        a = flipped ? c : r;
        b = flipped ? r : c;
        return int'(row_perm[a]) * MAX_SIZE + int'(col_perm[b]);
    endfunction

    task automatic apply_command(t_op op, t_idx i, t_idx j, t_digit d);
        int     lim;
        logic   ok;
        t_idx   tmp;
        t_digit dd;
        lim = (int'(size_reg) > MAX_SIZE) ? MAX_SIZE : int'(size_reg);
        ok  = (int'(i) < lim) && (int'(j) < lim);
        dd  = t_digit'(int'(d) % DIGIT_BASE);
        case (op)
            OP_WRITE: begin
                if (ok)
                    cell_digits[cell_at(i, j)] =
                        t_digit'((int'(dd) + DIGIT_BASE - int'(shift)) % DIGIT_BASE);
            end
            OP_SWAP_ROW, OP_SWAP_COL: begin
                if (ok) begin
                    // a row swap on the transposed view moves physical columns
                    if ((op == OP_SWAP_ROW) != flipped) begin
                        tmp = row_perm[i]; row_perm[i] = row_perm[j]; row_perm[j] = tmp;
                    end else begin
                        tmp = col_perm[i]; col_perm[i] = col_perm[j]; col_perm[j] = tmp;
                    end
                end
            end
            OP_INC: shift = t_digit'((int'(shift) + 1) % DIGIT_BASE);
            OP_DEC: shift = t_digit'((int'(shift) + DIGIT_BASE - 1) % DIGIT_BASE);
            OP_TRANSPOSE: flipped = ~flipped;
            OP_READ: begin
                if (ok)
                    read_digits_q.push_back(t_digit'(
                        (int'(cell_digits[cell_at(i, j)]) + int'(shift)) % DIGIT_BASE));
                else
                    read_digits_q.push_back('0);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_digit want;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_SIZE; k++) begin
                row_perm[k] = t_idx'(k);
                col_perm[k] = t_idx'(k);
            end
            flipped    = 1'b0;
            shift      = '0;
            size_reg   = SIZE_RST;
            mismatches = 0;
            read_digits_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                size_reg = i_cfg.matrix_size;
            // results leaving now belong to commands taken at earlier edges
            if (i_res.valid && i_res.ready) begin
                if (read_digits_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result transfer: digit_out %0d", i_res.digit_out);
                    mismatches++;
                end else begin
                    want = read_digits_q.pop_front();
                    if (i_res.digit_out !== want) begin
                        if (mismatches < 10)
                            $display("digit_out mismatch: expected %0d, actual %0d",
                                     want, i_res.digit_out);
                        mismatches++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                apply_command(i_cmd.operation, i_cmd.first_index, i_cmd.second_index,
                              i_cmd.digit_in);
        end
        o_errors  <= mismatches;
        o_pending <= read_digits_q.size();
    end

endmodule

/* test/tb_digit_matrix_permute_transform_core.sv */
// stimulus and verdict for the digit matrix permute and transpose core
`timescale 1ns / 1ps
module tb_digit_matrix_permute_transform_core;
    import dmpt_pkg::*;

    localparam t_op OP_UNUSED = 3'd7;
    localparam int  PHASE_ITEMS = 130;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   gap_pct;
    int   stall_pct;
    int   stall_left = 0;
    int   lim;

    dmpt_cfg_if cfg_bus ();
    dmpt_cmd_if cmd_bus ();
    dmpt_res_if res_bus ();

    digit_matrix_permute_transform_core u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_bus),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    dmpt_matrix_checker u_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg     (cfg_bus),
        .i_cmd     (cmd_bus),
        .i_res     (res_bus),
        .o_errors  (fail_count),
        .o_pending (pending_count)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result side back-pressure in bursts
    always @(posedge clk) begin
        if (stall_pct == 0) begin
            stall_left    <= 0;
            res_bus.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            res_bus.ready <= (stall_left == 1);
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left    <= $urandom_range(1, 19);
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= 1'b1;
        end
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_cmd(t_op op, t_idx a, t_idx b, t_digit d);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.operation    <= op;
        cmd_bus.first_index  <= a;
        cmd_bus.second_index <= b;
        cmd_bus.digit_in     <= d;
        do @(posedge clk); while (!cmd_bus.ready);
    endtask

    // hold off until every read has answered and the core has gone quiet
    task automatic drain();
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_size(t_size v);
        drain();
        cfg_bus.valid       <= 1'b1;
        cfg_bus.matrix_size <= v;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        lim = (int'(v) > MAX_SIZE_DEF) ? MAX_SIZE_DEF : int'(v);
    endtask

    function automatic t_idx pick_index(int n);
        if (n == 0 || $urandom_range(0, 7) == 0)
            return t_idx'($urandom_range(0, 15));
        return t_idx'($urandom_range(0, n - 1));
    endfunction

    task automatic random_cmd();
        int  roll;
        t_op op;
        roll = $urandom_range(0, 99);
        if (roll < 30)      op = OP_READ;
        else if (roll < 50) op = OP_WRITE;
        else if (roll < 62) op = OP_SWAP_ROW;
        else if (roll < 74) op = OP_SWAP_COL;
        else if (roll < 82) op = OP_INC;
        else if (roll < 90) op = OP_DEC;
        else if (roll < 96) op = OP_TRANSPOSE;
        else                op = OP_UNUSED;
        send_cmd(op, pick_index(lim), pick_index(lim), t_digit'($urandom_range(0, 15)));
    endtask

    initial begin
        t_size phase_size [5];
        int    phase_gap  [5];
        int    phase_stall[5];

        rst_n                <= 1'b0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.matrix_size  <= SIZE_RST;
        cmd_bus.valid        <= 1'b0;
        cmd_bus.operation    <= OP_WRITE;
        cmd_bus.first_index  <= '0;
        cmd_bus.second_index <= '0;
        cmd_bus.digit_in     <= '0;
        gap_pct              <= 10;
        stall_pct            <= 10;
        lim = MAX_SIZE_DEF;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // fill every cell first so that no read ever hits an unwritten one
        for (int r = 0; r < MAX_SIZE_DEF; r++)
            for (int c = 0; c < MAX_SIZE_DEF; c++)
                send_cmd(OP_WRITE, t_idx'(r), t_idx'(c), t_digit'($urandom_range(0, 15)));

        // corners, digits above nine, swaps, offset wrap and transposed access
        send_cmd(OP_READ, 4'd0, 4'd0, '0);
        send_cmd(OP_READ, 4'd15, 4'd15, '0);
        send_cmd(OP_READ, 4'd0, 4'd15, '0);
        send_cmd(OP_READ, 4'd15, 4'd0, '0);
        send_cmd(OP_WRITE, 4'd15, 4'd15, DIGIT_MAX);
        send_cmd(OP_READ, 4'd15, 4'd15, '0);
        send_cmd(OP_WRITE, 4'd0, 4'd15, 4'd15);
        send_cmd(OP_READ, 4'd0, 4'd15, '0);
        send_cmd(OP_SWAP_ROW, 4'd0, 4'd15, '0);
        send_cmd(OP_SWAP_COL, 4'd0, 4'd15, '0);
        send_cmd(OP_READ, 4'd0, 4'd0, '0);
        send_cmd(OP_SWAP_ROW, 4'd3, 4'd3, '0);
        send_cmd(OP_INC, '0, '0, '0);
        send_cmd(OP_DEC, '0, '0, '0);
        send_cmd(OP_DEC, '0, '0, '0);
        send_cmd(OP_READ, 4'd15, 4'd15, '0);
        send_cmd(OP_TRANSPOSE, '0, '0, '0);
        send_cmd(OP_WRITE, 4'd2, 4'd7, 4'd4);
        send_cmd(OP_SWAP_ROW, 4'd1, 4'd2, '0);
        send_cmd(OP_READ, 4'd1, 4'd7, '0);
        send_cmd(OP_TRANSPOSE, '0, '0, '0);
        send_cmd(OP_READ, 4'd7, 4'd1, '0);
        send_cmd(OP_UNUSED, 4'd5, 4'd5, 4'd5);

        // smallest size, then zero and an oversize value
        set_size(5'd1);
        send_cmd(OP_READ, 4'd0, 4'd0, '0);
        send_cmd(OP_READ, 4'd0, 4'd1, '0);
        send_cmd(OP_WRITE, 4'd1, 4'd0, 4'd3);
        send_cmd(OP_SWAP_ROW, 4'd0, 4'd15, '0);
        set_size(5'd0);
        send_cmd(OP_READ, 4'd0, 4'd0, '0);
        set_size(5'd31);
        send_cmd(OP_SWAP_COL, 4'd15, 4'd14, '0);
        send_cmd(OP_READ, 4'd15, 4'd15, '0);

        phase_size  = '{5'd16, t_size'($urandom_range(2, 15)), t_size'($urandom_range(0, 31)),
                        t_size'($urandom_range(17, 31)), 5'd16};
        phase_gap   = '{10, 0, 25, 5, 0};
        phase_stall = '{10, 0, 25, 15, 0};
        for (int p = 0; p < 5; p++) begin
            set_size(phase_size[p]);
            gap_pct   <= phase_gap[p];
            stall_pct <= phase_stall[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == PHASE_ITEMS / 2)
                    drain();
                random_cmd();
            end
        end

        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
